>>> design/tpmp_pkg.sv
// Shared types and constants for the trapezoid PWM move profiler.
`default_nettype none

package tpmp_pkg;

	localparam int DIST_W = 24;
	localparam int DUTY_W = 32;
	localparam int SPEED_W = 7;
	localparam int IR_W = 8;
	localparam int PERIOD_W = 32;

	// reset value of the period register
	localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = 32'd2000000;

	typedef struct packed {
		logic opcode;
		logic [DIST_W-1:0] move_distance;
		logic [SPEED_W-1:0] move_speed;
		logic [DIST_W-1:0] left_distance;
		logic [DIST_W-1:0] right_distance;
		logic [IR_W-1:0] ir_left_state;
		logic [IR_W-1:0] ir_right_state;
	} item_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_cycle;
		logic motor_run;
		logic [1:0] move_phase;
		logic move_done;
	} result_t;

endpackage

`default_nettype wire

>>> design/trapezoid_pwm_move_profiler_core.sv
// Trapezoid PWM move profiler: period decode, phase machine and result register.
//
// Usage:
//   item channel (item_valid/item_stall/item_data): a start beat latches target
//   distance and speed; odometry beats carry both wheel distances and the two
//   obstacle sensor states. Every accepted beat yields exactly one result beat.
//   result channel (res_valid/res_stall/res_data): duty, run flag, phase, done.
//   cfg_we/cfg_wdata write the PWM period. A write decodes period/10 and period/100,
//   then period%100 from them; item_stall is high during the write cycle and the
//   one after it.
// Result path: an accepted beat is held in the input register; its result is
//   registered once the result register is free and visible on res_* from then on.
// Throughput: one beat per cycle unless res_stall or a period write holds it. The phase
//   check, duty step and second check sit between the input register and the
//   state/result registers, so a beat sees everything the previous beat left.
// Reset: phase idle, duty and move state zero, period 2000000 with its decoded
//   quotients and remainder preloaded, both channels empty.
// Receiver stall: the result register holds; one more beat is taken into the
//   input register, after which item_stall rises until the result drains.
`default_nettype none

module trapezoid_pwm_move_profiler_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic item_stall,
	input  wire tpmp_pkg::item_t item_data,
	output logic res_valid,
	input  wire logic res_stall,
	output tpmp_pkg::result_t res_data,
	input  wire logic cfg_we,
	input  wire logic [tpmp_pkg::PERIOD_W-1:0] cfg_wdata
);

	localparam int DW = tpmp_pkg::DIST_W;
	localparam int UW = tpmp_pkg::DUTY_W;
	localparam int PW = tpmp_pkg::PERIOD_W;
	localparam int SW = tpmp_pkg::SPEED_W;
	localparam int IW = tpmp_pkg::IR_W;

	// reciprocal constants: x/10 = (x*M10)>>35, x/100 = (x*M100)>>37 for 32-bit x
	localparam logic [PW-1:0] M10 = 32'hCCCCCCCD;
	localparam logic [PW-1:0] M100 = 32'h51EB851F;
	localparam int Q10_W = 2 * PW - 35;
	localparam int Q100_W = 2 * PW - 37;
	// small divide by 100 for products below 2^14: (x*5243)>>19
	localparam logic [26:0] M100_SMALL = 27'd5243;

	localparam logic [Q10_W-1:0] Q10_RST = Q10_W'(tpmp_pkg::PWM_PERIOD_RST / 10);
	localparam logic [Q100_W-1:0] Q100_RST = Q100_W'(tpmp_pkg::PWM_PERIOD_RST / 100);
	localparam logic [6:0] R100_RST = 7'(tpmp_pkg::PWM_PERIOD_RST % 100);

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_UP     = 2'd1,
		PH_CRUISE = 2'd2,
		PH_DOWN   = 2'd3
	} phase_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_ODOM  = 1'b1
	} opcode_t;

	typedef struct packed {
		phase_t ph;
		logic [DW-1:0] rd;
		logic done;
	} chk_t;

	// ---------------- period register and its decode ----------------
	logic [PW-1:0] period_q;
	logic cfg_busy1_q;
	logic cfg_busy2_q;
	logic [Q10_W-1:0] q10_q;
	logic [Q100_W-1:0] q100_q;
	logic [6:0] r100_q;
	logic [2*PW-1:0] prod10;
	logic [2*PW-1:0] prod100;
	logic [PW-1:0] rem100;

	assign prod10 = (2*PW)'(period_q) * (2*PW)'(M10);
	assign prod100 = (2*PW)'(period_q) * (2*PW)'(M100);
	assign rem100 = period_q - PW'(q100_q) * PW'(100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= tpmp_pkg::PWM_PERIOD_RST;
			cfg_busy1_q <= 1'b0;
			cfg_busy2_q <= 1'b0;
			q10_q <= Q10_RST;
			q100_q <= Q100_RST;
			r100_q <= R100_RST;
		end else begin
			cfg_busy1_q <= cfg_we;
			cfg_busy2_q <= cfg_busy1_q;
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (cfg_busy1_q) begin
				q10_q <= prod10[2*PW-1:35];
				q100_q <= prod100[2*PW-1:37];
			end
			if (cfg_busy2_q) begin
				r100_q <= rem100[6:0];
			end
		end
	end

	// ---------------- input register and handshake ----------------
	tpmp_pkg::item_t s1_q;
	logic s1_valid_q;
	logic res_valid_q;
	logic advance;
	logic take;

	assign advance = s1_valid_q & (~res_valid_q | ~res_stall);
	assign item_stall = cfg_we | cfg_busy1_q | (s1_valid_q & ~advance);
	assign take = item_valid & ~item_stall;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s1_q <= item_data;
		end
	end

	// ---------------- phase checks ----------------
	// Leaves every phase whose hold condition fails, cascading.
	function automatic chk_t check_phase(
		input phase_t ph,
		input logic [UW-1:0] duty,
		input logic [DW-1:0] trav,
		input logic [DW-1:0] rd,
		input logic [DW-1:0] tgt,
		input logic [UW-1:0] sd,
		input logic [UW-1:0] ed,
		input logic [IW-1:0] irl,
		input logic [IW-1:0] irr
	);
		chk_t c;
		logic clear;
		logic near;
		logic [DW:0] trav_sum;
		c.ph = ph;
		c.rd = rd;
		c.done = 1'b0;
		clear = (irl == '0) && (irr == '0);
		near = (irl <= IW'(1)) && (irr <= IW'(1));
		if (c.ph == PH_UP && !(duty <= ed && {trav, 1'b0} < {1'b0, tgt} && clear)) begin
			c.rd = trav;
			c.ph = PH_CRUISE;
		end
		trav_sum = {1'b0, trav} + {1'b0, c.rd};
		if (c.ph == PH_CRUISE && !(trav_sum < {1'b0, tgt} && clear)) begin
			c.ph = PH_DOWN;
		end
		if (c.ph == PH_DOWN && !(trav < tgt && duty >= sd && near)) begin
			c.ph = PH_IDLE;
			c.done = 1'b1;
		end
		return c;
	endfunction

	// ---------------- move state ----------------
	phase_t phase_q;
	logic [UW-1:0] duty_q;
	logic [UW-1:0] sd_q;
	logic [UW-1:0] ed_q;
	logic [UW-1:0] step_q;
	logic [DW-1:0] target_q;
	logic [DW-1:0] trav_q;
	logic [DW-1:0] ramp_q;
	tpmp_pkg::result_t res_q;

	phase_t phase_n;
	logic [UW-1:0] duty_n;
	logic [UW-1:0] sd_n;
	logic [UW-1:0] ed_n;
	logic [UW-1:0] step_n;
	logic [DW-1:0] target_n;
	logic [DW-1:0] trav_n;
	logic [DW-1:0] ramp_n;
	logic done_n;

	// end duty = speed*q100 + floor(speed*r100/100), saturated
	logic [13:0] frac_x;
	logic [26:0] frac_p;
	logic [SW+PW-1:0] ed_wide;
	logic [UW-1:0] ed_start;

	assign frac_x = 14'(s1_q.move_speed) * 14'(r100_q);
	assign frac_p = 27'(frac_x) * M100_SMALL;
	assign ed_wide = (SW+PW)'(q100_q) * (SW+PW)'(s1_q.move_speed) + (SW+PW)'(frac_p[26:19]);
	assign ed_start = (|ed_wide[SW+PW-1:UW]) ? '1 : ed_wide[UW-1:0];

	always_comb begin
		chk_t c1;
		chk_t c2;
		logic [UW:0] up_sum;
		logic [UW-1:0] duty_a;
		logic [DW:0] wheel_sum;
		logic [DW-1:0] trav_a;
		phase_n = phase_q;
		duty_n = duty_q;
		sd_n = sd_q;
		ed_n = ed_q;
		step_n = step_q;
		target_n = target_q;
		trav_n = trav_q;
		ramp_n = ramp_q;
		done_n = 1'b0;
		c1 = check_phase(phase_q, duty_q, trav_q, ramp_q, target_q, sd_q, ed_q,
			s1_q.ir_left_state, s1_q.ir_right_state);
		up_sum = {1'b0, duty_q} + {1'b0, step_q};
		duty_a = duty_q;
		if (c1.ph == PH_UP) begin
			duty_a = up_sum[UW] ? '1 : up_sum[UW-1:0];
		end else if (c1.ph == PH_DOWN) begin
			duty_a = (duty_q >= step_q) ? duty_q - step_q : '0;
		end
		wheel_sum = {1'b0, s1_q.left_distance} + {1'b0, s1_q.right_distance};
		trav_a = wheel_sum[DW:1];
		c2 = check_phase(c1.ph, duty_a, trav_a, c1.rd, target_q, sd_q, ed_q,
			s1_q.ir_left_state, s1_q.ir_right_state);
		if (s1_q.opcode == OP_START) begin
			target_n = s1_q.move_distance;
			sd_n = UW'(q10_q);
			step_n = UW'(q100_q);
			ed_n = ed_start;
			duty_n = UW'(q10_q);
			trav_n = '0;
			ramp_n = '0;
			phase_n = PH_UP;
		end else if (phase_q != PH_IDLE) begin
			if (c1.done) begin
				phase_n = c1.ph;
				ramp_n = c1.rd;
				done_n = 1'b1;
			end else begin
				duty_n = duty_a;
				trav_n = trav_a;
				phase_n = c2.ph;
				ramp_n = c2.rd;
				done_n = c2.done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			duty_q <= '0;
			sd_q <= '0;
			ed_q <= '0;
			step_q <= '0;
			target_q <= '0;
			trav_q <= '0;
			ramp_q <= '0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (advance) begin
				phase_q <= phase_n;
				duty_q <= duty_n;
				sd_q <= sd_n;
				ed_q <= ed_n;
				step_q <= step_n;
				target_q <= target_n;
				trav_q <= trav_n;
				ramp_q <= ramp_n;
				res_valid_q <= 1'b1;
				res_q.duty_cycle <= duty_n;
				res_q.motor_run <= (phase_n != PH_IDLE);
				res_q.move_phase <= phase_n;
				res_q.move_done <= done_n;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_data = res_q;

	// ---------------- assertions ----------------
	a_cfg_blocks_items: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> item_stall)
		else $error("item taken while period decode in flight");

	a_done_means_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.move_done) |-> (res_data.move_phase == PH_IDLE && !res_data.motor_run))
		else $error("move done reported with motor still running");

	a_start_ramps_up: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && s1_q.opcode == OP_START) |=> (res_valid && res_data.move_phase == PH_UP
		&& !res_data.move_done))
		else $error("start beat did not enter ramp up");

	a_state_tracks_result: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) |-> (res_data.move_phase == phase_q && res_data.duty_cycle == duty_q))
		else $error("result register disagrees with move state");

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the trapezoid PWM move profiler core.
`timescale 1ns / 100ps

module testbench;

	localparam int DIST_W = tpmp_pkg::DIST_W;
	localparam int DUTY_W = tpmp_pkg::DUTY_W;
	localparam int SPEED_W = tpmp_pkg::SPEED_W;
	localparam int IR_W = tpmp_pkg::IR_W;
	localparam int PERIOD_W = tpmp_pkg::PERIOD_W;

	// Item opcodes and sensor codes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_ODOM  = 1'b1;
	localparam logic [IR_W-1:0] IR_CLEAR = 8'd0;
	localparam logic [IR_W-1:0] IR_NEAR  = 8'd1;

	localparam logic [DUTY_W-1:0] DUTY_ALL = '1;
	localparam int DIST_ALL = 24'hFF_FFFF;

	// Run limit: about 1400 beats, worst receiver stall, long holds and
	// config writes add up to far less than this.
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_RAMP_UP   = 2'd1,
		PH_CRUISE    = 2'd2,
		PH_RAMP_DOWN = 2'd3
	} move_phase_e;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	tpmp_pkg::item_t item_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	tpmp_pkg::result_t res_data;
	logic cfg_we = 1'b0;
	logic [PERIOD_W-1:0] cfg_wdata = '0;

	trapezoid_pwm_move_profiler_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_data(item_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Profile model: its own copy of the period register and move state.
	// ------------------------------------------------------------------
	logic [PERIOD_W-1:0] model_period = tpmp_pkg::PWM_PERIOD_RST;
	move_phase_e prof_phase = PH_IDLE;
	logic [DUTY_W-1:0] prof_duty = '0;
	logic [DUTY_W-1:0] prof_floor_duty = '0;  // duty at move start, ramp-down floor
	logic [DUTY_W-1:0] prof_top_duty = '0;    // cruise duty
	logic [DUTY_W-1:0] prof_duty_incr = '0;
	logic [DIST_W-1:0] prof_target = '0;
	logic [DIST_W-1:0] prof_travel = '0;
	logic [DIST_W-1:0] prof_ramp_len = '0;

	// Drop out of every phase whose hold condition fails. Phases cascade,
	// so one beat can go ramp up -> cruise -> ramp down -> idle.
	// Returns 1 when the move ends here.
	function automatic bit leave_phases(input logic [IR_W-1:0] irl, input logic [IR_W-1:0] irr);
		bit clear;
		clear = (irl == IR_CLEAR) && (irr == IR_CLEAR);
		if (prof_phase == PH_RAMP_UP &&
			!(prof_duty <= prof_top_duty && {prof_travel, 1'b0} < {1'b0, prof_target} && clear)) begin
			prof_ramp_len = prof_travel;
			prof_phase = PH_CRUISE;
		end
		if (prof_phase == PH_CRUISE &&
			!({1'b0, prof_travel} + {1'b0, prof_ramp_len} < {1'b0, prof_target} && clear))
			prof_phase = PH_RAMP_DOWN;
		if (prof_phase == PH_RAMP_DOWN &&
			!(prof_travel < prof_target && prof_duty >= prof_floor_duty &&
			irl <= IR_NEAR && irr <= IR_NEAR)) begin
			prof_phase = PH_IDLE;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the model by one accepted beat and return the result it implies.
	function automatic tpmp_pkg::result_t profile_beat(input tpmp_pkg::item_t it);
		tpmp_pkg::result_t r;
		bit done;
		logic [38:0] cruise_prod;
		logic [32:0] duty_sum;
		logic [DIST_W:0] wheel_sum;
		done = 1'b0;
		if (it.opcode == OP_START) begin
			// restart from scratch, even mid-move; wheel and sensor fields unused
			prof_target = it.move_distance;
			prof_floor_duty = model_period / 10;
			prof_duty_incr = model_period / 100;
			cruise_prod = (39'(it.move_speed) * 39'(model_period)) / 100;
			prof_top_duty = (cruise_prod > 39'(DUTY_ALL)) ? DUTY_ALL : cruise_prod[DUTY_W-1:0];
			prof_duty = prof_floor_duty;
			prof_travel = '0;
			prof_ramp_len = '0;
			prof_phase = PH_RAMP_UP;
		end else if (prof_phase != PH_IDLE) begin
			done = leave_phases(it.ir_left_state, it.ir_right_state);
			if (!done) begin
				if (prof_phase == PH_RAMP_UP) begin
					duty_sum = {1'b0, prof_duty} + {1'b0, prof_duty_incr};
					prof_duty = duty_sum[32] ? DUTY_ALL : duty_sum[DUTY_W-1:0];
				end else if (prof_phase == PH_RAMP_DOWN) begin
					prof_duty = (prof_duty >= prof_duty_incr) ? prof_duty - prof_duty_incr : '0;
				end
				wheel_sum = {1'b0, it.left_distance} + {1'b0, it.right_distance};
				prof_travel = wheel_sum[DIST_W:1];
				done = leave_phases(it.ir_left_state, it.ir_right_state);
			end
		end
		// odometry while idle leaves everything as it was
		r.duty_cycle = prof_duty;
		r.motor_run = (prof_phase != PH_IDLE);
		r.move_phase = prof_phase;
		r.move_done = done;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Shared bookkeeping between the stimulus, driver and monitor.
	// ------------------------------------------------------------------
	tpmp_pkg::item_t pending_beats[$];
	tpmp_pkg::result_t expected_results[$];
	int send_idle_pct = 23;
	int recv_idle_pct = 85;
	int hold_requests = 0;   // bumped by the stimulus to ask for a long receiver hold
	int error_count = 0;
	int cycle_count = 0;

	// Driver: presents queued beats, idling at random between them.
	// A beat is predicted at the edge it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item_data <= '0;
		end else begin
			if (item_valid && !item_stall)
				expected_results.push_back(profile_beat(item_data));
			// payload holds while stalled; otherwise pick the next beat or idle
			if (!item_valid || !item_stall) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item_data <= pending_beats.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Monitor: checks each result beat against the oldest prediction and
	// drives the receiver stall (random, or a long counted hold on request).
	int hold_left = 0;
	int hold_served = 0;
	always @(posedge clk or negedge arst_n) begin
		tpmp_pkg::result_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_left <= 0;
			hold_served <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none actual %h",
						$time, res_data);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("duty_cycle", want.duty_cycle, res_data.duty_cycle);
					check_field("motor_run", want.motor_run, res_data.motor_run);
					check_field("move_phase", want.move_phase, res_data.move_phase);
					check_field("move_done", want.move_done, res_data.move_done);
				end
			end
			if (hold_served != hold_requests) begin
				hold_served <= hold_requests;
				hold_left <= HOLD_CYCLES;
				res_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	task automatic push_start(input logic [DIST_W-1:0] move_dist,
		input logic [SPEED_W-1:0] speed);
		tpmp_pkg::item_t it;
		it = tpmp_pkg::item_t'({$urandom, $urandom, $urandom});  // ignored fields stay random
		it.opcode = OP_START;
		it.move_distance = move_dist;
		it.move_speed = speed;
		pending_beats.push_back(it);
	endtask

	task automatic push_odom(input logic [DIST_W-1:0] l, input logic [DIST_W-1:0] r,
		input logic [IR_W-1:0] irl, input logic [IR_W-1:0] irr);
		tpmp_pkg::item_t it;
		it = tpmp_pkg::item_t'({$urandom, $urandom, $urandom});
		it.opcode = OP_ODOM;
		it.left_distance = l;
		it.right_distance = r;
		it.ir_left_state = irl;
		it.ir_right_state = irr;
		pending_beats.push_back(it);
	endtask

	// Mostly well-formed moves: a start, then odometry creeping toward the
	// target with a little wheel skew and the odd sensor event. Some raw
	// noise beats mixed in (odometry while idle, starts mid-move).
	task automatic plan_moves(input int budget);
		int added;
		int len;
		int incr;
		int pos;
		int jit;
		int pick;
		int lw;
		logic [DIST_W-1:0] tgt;
		logic [SPEED_W-1:0] spd;
		logic [IR_W-1:0] irl;
		logic [IR_W-1:0] irr;
		added = 0;
		while (added < budget) begin
			if ($urandom_range(99) < 8) begin
				pending_beats.push_back(tpmp_pkg::item_t'({$urandom, $urandom, $urandom}));
				added++;
			end else begin
				pick = $urandom_range(99);
				if (pick < 20)
					tgt = DIST_W'($urandom_range(255));
				else if (pick < 70)
					tgt = DIST_W'($urandom_range(40000, 256));
				else
					tgt = DIST_W'($urandom);
				spd = ($urandom_range(9) == 0) ? SPEED_W'($urandom_range(127, 101))
					: SPEED_W'($urandom_range(100));
				push_start(tgt, spd);
				len = $urandom_range(60, 3);
				incr = tgt / len + 1;
				pos = 0;
				for (int k = 0; k < len; k++) begin
					pos += $urandom_range(2 * incr, 0);
					if (pos > DIST_ALL)
						pos = DIST_ALL;
					jit = $urandom_range(3);
					lw = (pos + jit > DIST_ALL) ? DIST_ALL : pos + jit;
					irl = IR_CLEAR;
					irr = IR_CLEAR;
					pick = $urandom_range(99);
					if (pick >= 97) begin
						if ($urandom_range(1))
							irl = IR_W'($urandom_range(255, 2));
						else
							irr = IR_W'($urandom_range(255, 2));
					end else if (pick >= 93) begin
						irl = IR_NEAR;
						irr = IR_NEAR;
					end else if (pick >= 85) begin
						if ($urandom_range(1))
							irl = IR_NEAR;
						else
							irr = IR_NEAR;
					end
					push_odom(DIST_W'(lw), DIST_W'((pos >= jit) ? pos - jit : 0), irl, irr);
				end
				added += len + 1;
			end
		end
	endtask

	// Wait until every queued beat was taken and every result checked.
	task automatic wait_drained();
		while (pending_beats.size() != 0 || item_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Period write; only called with the block drained.
	task automatic write_period(input logic [PERIOD_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_period = value;
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		logic [PERIOD_W-1:0] rnd_period;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset period (2000000): floor 200000, incr 20000.
		push_odom(24'hFF_FFFF, 24'hFF_FFFF, 8'hFF, 8'hFF);  // odometry while idle
		// full trapezoid: ramp up past cruise duty, cruise, near sensor, reach target
		push_start(24'd4096, 7'd12);
		push_odom(24'd100, 24'd100, IR_CLEAR, IR_CLEAR);
		push_odom(24'd200, 24'd202, IR_CLEAR, IR_CLEAR);
		push_odom(24'd300, 24'd300, IR_CLEAR, IR_CLEAR);
		push_odom(24'd2000, 24'd2001, IR_CLEAR, IR_CLEAR);
		push_odom(24'd3900, 24'd3901, IR_NEAR, IR_CLEAR);
		push_odom(24'd4095, 24'd4097, IR_CLEAR, IR_NEAR);
		push_odom(24'd5000, 24'd5000, IR_CLEAR, IR_CLEAR);  // idle again
		// speed above 100, max target reached on the first odometry beat, then a blocked sensor once idle
		push_start(24'hFF_FFFF, 7'd127);
		push_odom(24'hFF_FFFF, 24'hFF_FFFF, IR_CLEAR, IR_CLEAR);
		push_odom(24'd10, 24'd10, IR_CLEAR, 8'hFF);
		// zero speed, then a restart mid-move with zero distance
		push_start(24'h000800, 7'd0);
		push_odom(24'd5, 24'd6, IR_CLEAR, IR_CLEAR);
		push_start(24'd0, 7'd100);
		push_odom(24'd0, 24'd0, IR_CLEAR, IR_CLEAR);
		// ramp down ends by duty dropping under the start duty
		push_start(24'hFF_FFFF, 7'd11);
		push_odom(24'd10, 24'd10, IR_CLEAR, IR_CLEAR);
		push_odom(24'd20, 24'd20, IR_CLEAR, IR_CLEAR);
		push_odom(24'd30, 24'd30, IR_NEAR, IR_NEAR);
		push_odom(24'd40, 24'd40, IR_NEAR, IR_CLEAR);
		push_odom(24'd50, 24'd50, IR_CLEAR, IR_CLEAR);
		// near left sensor forces ramp down and ends the move at once; blocked left sensor then hits idle
		push_start(24'd1000, 7'd100);
		push_odom(24'd600, 24'd600, IR_NEAR, IR_CLEAR);
		push_odom(24'd700, 24'd700, 8'h02, IR_CLEAR);
		wait_drained();

		// Random moves; sender 23%, receiver 85% idle. A long receiver hold
		// while beats are still on offer backs the block up.
		plan_moves(180);
		hold_requests++;
		wait_drained();

		write_period(32'd1);
		plan_moves(200);
		wait_drained();

		send_idle_pct = 85;
		recv_idle_pct = 23;
		write_period(32'hFFFF_FFFF);
		plan_moves(220);
		wait_drained();

		write_period(32'd1000);
		plan_moves(200);
		hold_requests++;
		wait_drained();

		// no idling from here on
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rnd_period = $urandom;
		if (rnd_period == '0)
			rnd_period = 32'd1;
		write_period(rnd_period);
		plan_moves(200);
		wait_drained();

		write_period(32'd2000000);
		plan_moves(200);
		wait_drained();

		// allow a little slack before the final report
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
design/tpmp_pkg.sv
design/trapezoid_pwm_move_profiler_core.sv
verif/testbench.sv
